@@ hdl/rrb_pkg.sv @@
// ----------------------------------------------------------------------------
// rrb_pkg
// Shared types, widths and helpers for the rotating ring buffer core.
// ----------------------------------------------------------------------------
package rrb_pkg;

   localparam int DEPTH      = 16;
   localparam int PTR_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int SUM_W      = CNT_W + 1;

   localparam int ACTION_W   = 3;
   localparam int DATA_W     = 32;
   localparam int POS_W      = 16;
   localparam int STATUS_W   = 2;
   localparam int FILL_W     = 5;
   localparam int DIV_CNT_W  = $clog2(POS_W + 1);

   localparam int REQ_TDATA_W = 56;   // 3 + 32 + 16 = 51, padded to bytes
   localparam int RSP_TDATA_W = 40;   // 32 + 2 + 5 = 39, padded to bytes

   typedef enum logic [ACTION_W-1:0] {
      ACT_APPEND  = 3'd0,
      ACT_EXTRACT = 3'd1,
      ACT_PEEK    = 3'd2,
      ACT_FWD     = 3'd3,
      ACT_BACK    = 3'd4,
      ACT_INDEX   = 3'd5
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   // (base + off) mod DEPTH, with base < DEPTH and off <= DEPTH
   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(off);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

endpackage

@@ hdl/rrb_mod.sv @@
// ----------------------------------------------------------------------------
// rrb_mod
// Bit-serial restoring remainder: position mod element count, one bit a cycle.
// ----------------------------------------------------------------------------
module rrb_mod
   import rrb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [POS_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,    // nonzero
   output logic             done,
   output logic [CNT_W-1:0] remainder
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [POS_W-1:0]     dvd_ff, dvd_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]     dvs_ff, dvs_in;
   logic [SUM_W-1:0]     trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, dvd_ff[POS_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(POS_W);
         dvd_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[POS_W-2:0], 1'b0};
         if (trial >= SUM_W'(dvs_ff)) begin
            rem_in = CNT_W'(trial - SUM_W'(dvs_ff));
         end else begin
            rem_in = trial[CNT_W-1:0];
         end
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

@@ hdl/rotating_ring_buffer_core.sv @@
// ----------------------------------------------------------------------------
// rotating_ring_buffer_core
// Ring of signed words with a current position: append, extract, peek,
// rotate forward/back and indexed read over one slot memory.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  action, value, position
//  rsp      out  rsp_tvalid/rsp_tready  data, status, fill
//
//  One word at a time: append, error/no-op actions and rotations of a full
//  ring go from accept through execute to the result; extract/peek and
//  rotations of a partly filled ring add a memory read and then a
//  write-back (rotations) or data capture; indexed read first waits on the
//  bit-serial position mod count unit, then does the same read.
//  A finished result sits in the output register; the next word is accepted
//  while it waits, and is held before its own result until that one drains.
//  Reset empties the ring at once; slot contents are not cleared.
// ----------------------------------------------------------------------------
module rotating_ring_buffer_core
   import rrb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // action[2:0], value[34:3], position[50:35]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // data[31:0], status[33:32], fill[38:34]
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_DIV,
      S_RD,
      S_USE,
      S_DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic [PTR_W-1:0]          head_ff, head_in;
   logic [CNT_W-1:0]          occ_ff, occ_in;
   logic [ACTION_W-1:0]       act_ff, act_in;
   logic signed [DATA_W-1:0]  value_ff, value_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic signed [DATA_W-1:0]  data_ff, data_in;
   status_type                status_ff, status_in;
   logic [PTR_W-1:0]          rd_addr_ff, rd_addr_in;
   logic [PTR_W-1:0]          wr_addr_ff, wr_addr_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]    rsp_data_ff, rsp_data_in;

   logic [DATA_W-1:0]         slots [DEPTH];
   logic [DATA_W-1:0]         rd_data_ff;
   logic                      mem_we;
   logic [PTR_W-1:0]          mem_waddr;
   logic [DATA_W-1:0]         mem_wdata;

   logic                      div_start;
   logic                      div_done;
   logic [CNT_W-1:0]          div_rem;

   rrb_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (pos_ff),
      .divisor   (occ_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      occ_in       = occ_ff;
      act_in       = act_ff;
      value_in     = value_ff;
      pos_in       = pos_ff;
      data_in      = data_ff;
      status_in    = status_ff;
      rd_addr_in   = rd_addr_ff;
      wr_addr_in   = wr_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = wr_addr_ff;
      mem_wdata    = rd_data_ff;
      div_start    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               act_in   = req_tdata[2:0];
               value_in = req_tdata[34:3];
               pos_in   = req_tdata[50:35];
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            data_in   = '0;
            status_in = STAT_OK;
            state_in  = S_DONE;
            unique case (act_ff)
               ACT_APPEND: begin
                  if (occ_ff == CNT_W'(DEPTH)) begin
                     status_in = STAT_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = wrap_add(head_ff, occ_ff);
                     mem_wdata = value_ff;
                     occ_in    = occ_ff + CNT_W'(1);
                  end
               end
               ACT_EXTRACT: begin
                  if (occ_ff == '0) begin
                     status_in = STAT_EMPTY;
                  end else begin
                     rd_addr_in = head_ff;
                     occ_in     = occ_ff - CNT_W'(1);
                     head_in    = (occ_ff == CNT_W'(1)) ? '0 : wrap_add(head_ff, CNT_W'(1));
                     state_in   = S_RD;
                  end
               end
               ACT_PEEK: begin
                  if (occ_ff == '0) begin
                     status_in = STAT_EMPTY;
                  end else begin
                     rd_addr_in = head_ff;
                     state_in   = S_RD;
                  end
               end
               ACT_FWD: begin
                  if (occ_ff != '0) begin
                     head_in = wrap_add(head_ff, CNT_W'(1));
                     // not full: copy current to the tail to keep the span contiguous
                     if (occ_ff != CNT_W'(DEPTH)) begin
                        rd_addr_in = head_ff;
                        wr_addr_in = wrap_add(head_ff, occ_ff);
                        state_in   = S_RD;
                     end
                  end
               end
               ACT_BACK: begin
                  if (occ_ff != '0) begin
                     head_in = wrap_add(head_ff, CNT_W'(DEPTH - 1));
                     if (occ_ff != CNT_W'(DEPTH)) begin
                        rd_addr_in = wrap_add(head_ff, occ_ff - CNT_W'(1));
                        wr_addr_in = wrap_add(head_ff, CNT_W'(DEPTH - 1));
                        state_in   = S_RD;
                     end
                  end
               end
               ACT_INDEX: begin
                  if (occ_ff == '0) begin
                     status_in = STAT_EMPTY;
                  end else begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
               end
               default: begin
               end
            endcase
         end
         S_DIV: begin
            if (div_done) begin
               rd_addr_in = wrap_add(head_ff, div_rem);
               state_in   = S_RD;
            end
         end
         S_RD: begin
            state_in = S_USE;
         end
         S_USE: begin
            if (act_ff == ACT_FWD || act_ff == ACT_BACK) begin
               mem_we = 1'b1;
            end else begin
               data_in = rd_data_ff;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, FILL_W'(occ_ff), status_ff, data_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff      <= act_in;
      value_ff    <= value_in;
      pos_ff      <= pos_in;
      data_ff     <= data_in;
      status_ff   <= status_in;
      rd_addr_ff  <= rd_addr_in;
      wr_addr_ff  <= wr_addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   // slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slots[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= slots[rd_addr_ff];
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
